// ===== src/sida_pkg.sv =====
package sida_pkg;

    localparam int DATA_W          = 64;
    localparam int VALUE_BITS_DEF  = 64;
    localparam int CHAR_W          = 6;
    localparam int TDATA_OUT_W     = 8;
    localparam int REM_W           = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
    localparam logic [REM_W:0]    RADIX      = (REM_W + 1)'(10);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIGIT,
        ST_SIGN
    } state_t;

endpackage

// ===== src/signed_int_to_decimal_ascii.sv =====
// the value is taken in ST_IDLE; characters then come out least significant digit
// first, each digit the remainder of restoring divide-by-ten steps over the
// magnitude (one restoring divide-by-ten step per cycle over the magnitude),
// and a minus sign follows the last digit when the value is negative;
// the next item is taken as soon as the last character sits in the output register
// reset clears the state machine and output valid only
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sida_pkg::DATA_W-1:0]      s_tdata,   // value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sida_pkg::TDATA_OUT_W-1:0] m_tdata,   // text_char, zero pad
    output logic                             m_tlast    // last
);
    import sida_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   nz_reg, nz_next;
    logic                   neg_reg, neg_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    logic [VALUE_BITS-1:0]  in_val;
    logic [REM_W:0]         rem_shift;
    logic                   ge;
    logic                   out_free;
    logic                   cnt_done;

    assign in_val    = s_tdata[VALUE_BITS-1:0];
    assign rem_shift = {rem_reg, mag_reg[VALUE_BITS-1]};
    assign ge        = (rem_shift >= RADIX);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cnt_done  = (cnt_reg == CNT_W'(VALUE_BITS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_done) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    if (nz_reg) begin
                        state_next = ST_DIV;
                    end else if (neg_reg) begin
                        state_next = ST_SIGN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_tready      = 1'b0;
        mag_next      = mag_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        nz_next       = nz_reg;
        neg_next      = neg_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    neg_next = in_val[VALUE_BITS-1];
                    mag_next = in_val[VALUE_BITS-1] ? (~in_val + VALUE_BITS'(1)) : in_val;
                    rem_next = '0;
                    cnt_next = '0;
                    nz_next  = 1'b0;
                end
            end
            ST_DIV: begin
                // one restoring divide-by-ten step, quotient shifts back in
                rem_next = ge ? REM_W'(rem_shift - RADIX) : rem_shift[REM_W-1:0];
                mag_next = {mag_reg[VALUE_BITS-2:0], ge};
                nz_next  = nz_reg | ge;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_DIGIT: begin
                if (out_free) begin
                    char_next     = CHAR_ZERO + CHAR_W'(rem_reg);
                    last_next     = !nz_reg && !neg_reg;
                    m_tvalid_next = 1'b1;
                    rem_next      = '0;
                    cnt_next      = '0;
                    nz_next       = 1'b0;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    char_next     = CHAR_MINUS;
                    last_next     = 1'b1;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        nz_reg   <= nz_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(TDATA_OUT_W - CHAR_W)'(0), char_reg};
    assign m_tlast  = last_reg;

endmodule
